// ===== rtl/core/udrq_pkg.sv =====
// ----------------------------------------------------------------------------
// udrq_pkg
// Shared depths, pointer widths and codes for the dual UART ring queue.
// ----------------------------------------------------------------------------
package udrq_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 128;

    localparam int RX_PTR_W = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PTR_W = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;

    localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_DEVICE = 2'd0;
    localparam op_t OP_READ   = 2'd1;
    localparam op_t OP_WRITE  = 2'd2;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_TX_FULL  = 2'd1;
    localparam status_t STATUS_RX_EMPTY = 2'd2;

endpackage

// ===== rtl/core/uart_dual_ring_queue.sv =====
// ----------------------------------------------------------------------------
// uart_dual_ring_queue
// Receive and transmit byte ring queues between a UART and software.
// ----------------------------------------------------------------------------
// One word is taken per clock. Each accepted word is handled in the cycle it
// is taken: pointers, the interrupt enable and the event counters update at
// the accepting edge, and the result word is in the output register in the
// next cycle. The store arrays are read synchronously at the same edge, so a
// popped byte is presented from the read-data register with the rest of the
// result. s_ready drops only while a result word waits on m_ready; with
// m_ready held high the block sustains one word per cycle. Each queue keeps
// one slot free, so the receive queue holds at most RX_DEPTH-1 bytes and the
// transmit queue at most TX_DEPTH-1 bytes. On a device event the received
// byte is stored before the transmitter-empty pop. A received byte arriving
// on a full receive queue is dropped but still counted; a transmitter-empty
// event on an empty transmit queue clears the interrupt enable and is still
// counted. Both counters wrap at 2^32.
module uart_dual_ring_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input word
    input  logic                          s_valid,
    output logic                          s_ready,
    input  udrq_pkg::op_t                 s_operation,
    input  logic                          s_rx_has_byte,
    input  logic                          s_tx_empty,
    input  logic [udrq_pkg::BYTE_W-1:0]   s_rx_byte,
    input  logic [udrq_pkg::BYTE_W-1:0]   s_write_byte,
    // result word
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [udrq_pkg::BYTE_W-1:0]   m_data_out,
    output logic                          m_data_valid,
    output udrq_pkg::status_t             m_status,
    output logic                          m_tx_irq_enable,
    output logic [udrq_pkg::COUNT_W-1:0]  m_rx_event_count,
    output logic [udrq_pkg::COUNT_W-1:0]  m_tx_event_count
);
    import udrq_pkg::*;

    // byte stores, contents undefined until written
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

    // queue state
    logic [RX_PTR_W-1:0] rx_wr_pos_reg, rx_wr_pos_next;
    logic [RX_PTR_W-1:0] rx_rd_pos_reg, rx_rd_pos_next;
    logic [TX_PTR_W-1:0] tx_wr_pos_reg, tx_wr_pos_next;
    logic [TX_PTR_W-1:0] tx_rd_pos_reg, tx_rd_pos_next;
    logic                tx_irq_reg, tx_irq_next;
    logic [COUNT_W-1:0]  rx_events_reg, rx_events_next;
    logic [COUNT_W-1:0]  tx_events_reg, tx_events_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic                data_valid_reg, data_valid_next;
    logic                sel_rx_reg, sel_rx_next;
    status_t             status_reg, status_next;
    logic [BYTE_W-1:0]   rx_rd_data_reg;
    logic [BYTE_W-1:0]   tx_rd_data_reg;

    // per-word control
    logic                accept;
    logic                rx_push;
    logic                tx_push;
    logic [RX_PTR_W-1:0] rx_wr_inc;
    logic [RX_PTR_W-1:0] rx_rd_inc;
    logic [TX_PTR_W-1:0] tx_wr_inc;
    logic [TX_PTR_W-1:0] tx_rd_inc;
    logic                rx_full;
    logic                rx_empty;
    logic                tx_full;
    logic                tx_empty_q;

    // Take a new word whenever the output register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Wrapping successors of each position.
    assign rx_wr_inc = (rx_wr_pos_reg == RX_LAST) ? '0 : RX_PTR_W'(rx_wr_pos_reg + 1'b1);
    assign rx_rd_inc = (rx_rd_pos_reg == RX_LAST) ? '0 : RX_PTR_W'(rx_rd_pos_reg + 1'b1);
    assign tx_wr_inc = (tx_wr_pos_reg == TX_LAST) ? '0 : TX_PTR_W'(tx_wr_pos_reg + 1'b1);
    assign tx_rd_inc = (tx_rd_pos_reg == TX_LAST) ? '0 : TX_PTR_W'(tx_rd_pos_reg + 1'b1);

    // One free slot separates full from empty.
    assign rx_full    = (rx_wr_inc == rx_rd_pos_reg);
    assign rx_empty   = (rx_rd_pos_reg == rx_wr_pos_reg);
    assign tx_full    = (tx_wr_inc == tx_rd_pos_reg);
    assign tx_empty_q = (tx_rd_pos_reg == tx_wr_pos_reg);

    always_comb begin
        rx_wr_pos_next  = rx_wr_pos_reg;
        rx_rd_pos_next  = rx_rd_pos_reg;
        tx_wr_pos_next  = tx_wr_pos_reg;
        tx_rd_pos_next  = tx_rd_pos_reg;
        tx_irq_next     = tx_irq_reg;
        rx_events_next  = rx_events_reg;
        tx_events_next  = tx_events_reg;
        data_valid_next = data_valid_reg;
        sel_rx_next     = sel_rx_reg;
        status_next     = status_reg;
        rx_push         = 1'b0;
        tx_push         = 1'b0;

        if (accept) begin
            data_valid_next = 1'b0;
            sel_rx_next     = 1'b0;
            status_next     = STATUS_OK;
            case (s_operation)
                OP_DEVICE: begin
                    // store the received byte first, drop it on a full queue
                    if (s_rx_has_byte) begin
                        if (!rx_full) begin
                            rx_push        = 1'b1;
                            rx_wr_pos_next = rx_wr_inc;
                        end
                        rx_events_next = rx_events_reg + 1'b1;
                    end
                    // then hand the next transmit byte to the line
                    if (s_tx_empty) begin
                        if (!tx_empty_q) begin
                            data_valid_next = 1'b1;
                            tx_rd_pos_next  = tx_rd_inc;
                        end else begin
                            tx_irq_next = 1'b0;
                        end
                        tx_events_next = tx_events_reg + 1'b1;
                    end
                end
                OP_READ: begin
                    if (!rx_empty) begin
                        data_valid_next = 1'b1;
                        sel_rx_next     = 1'b1;
                        rx_rd_pos_next  = rx_rd_inc;
                    end else begin
                        status_next = STATUS_RX_EMPTY;
                    end
                end
                OP_WRITE: begin
                    if (tx_full) begin
                        status_next = STATUS_TX_FULL;
                    end else begin
                        tx_push        = 1'b1;
                        tx_wr_pos_next = tx_wr_inc;
                        tx_irq_next    = 1'b1;
                    end
                end
                default: begin
                    // unused code: report the current state, change nothing
                end
            endcase
        end

        // Hold a result until taken; a new word replaces it in the same cycle.
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_pos_reg <= '0;
            rx_rd_pos_reg <= '0;
            tx_wr_pos_reg <= '0;
            tx_rd_pos_reg <= '0;
            tx_irq_reg    <= 1'b0;
            rx_events_reg <= '0;
            tx_events_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            rx_wr_pos_reg <= rx_wr_pos_next;
            rx_rd_pos_reg <= rx_rd_pos_next;
            tx_wr_pos_reg <= tx_wr_pos_next;
            tx_rd_pos_reg <= tx_rd_pos_next;
            tx_irq_reg    <= tx_irq_next;
            rx_events_reg <= rx_events_next;
            tx_events_reg <= tx_events_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge aclk) begin
        data_valid_reg <= data_valid_next;
        sel_rx_reg     <= sel_rx_next;
        status_reg     <= status_next;
    end

    // Receive store: write on push, read the head on every accepted word.
    always_ff @(posedge aclk) begin
        if (rx_push) begin
            rx_mem[rx_wr_pos_reg] <= s_rx_byte;
        end
        if (accept) begin
            rx_rd_data_reg <= rx_mem[rx_rd_pos_reg];
        end
    end

    // Transmit store: a push to an empty queue lands on the slot being read.
    always_ff @(posedge aclk) begin
        if (tx_push) begin
            tx_mem[tx_wr_pos_reg] <= s_write_byte;
        end
        if (accept) begin
            tx_rd_data_reg <= tx_mem[tx_rd_pos_reg];
        end
    end

    // Drive zero on data_out whenever no byte is carried.
    assign m_valid          = m_valid_reg;
    assign m_data_valid     = data_valid_reg;
    assign m_data_out       = !data_valid_reg ? '0 :
                              (sel_rx_reg ? rx_rd_data_reg : tx_rd_data_reg);
    assign m_status         = status_reg;
    assign m_tx_irq_enable  = tx_irq_reg;
    assign m_rx_event_count = rx_events_reg;
    assign m_tx_event_count = tx_events_reg;

endmodule

// ===== rtl/core/udrq_checker.sv =====
// ----------------------------------------------------------------------------
// udrq_checker
// Port-level checks on the dual UART ring queue, bound to the top level.
// ----------------------------------------------------------------------------
module udrq_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [udrq_pkg::BYTE_W-1:0]   m_data_out,
    input  logic                          m_data_valid,
    input  udrq_pkg::status_t             m_status,
    input  logic                          m_tx_irq_enable,
    input  logic [udrq_pkg::COUNT_W-1:0]  m_rx_event_count,
    input  logic [udrq_pkg::COUNT_W-1:0]  m_tx_event_count
);
    import udrq_pkg::*;

    logic               have_last_reg;
    logic [COUNT_W-1:0] last_rx_reg;
    logic [COUNT_W-1:0] rx_delta;

    // Track the receive count of the previous delivered word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_last_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            have_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            last_rx_reg <= m_rx_event_count;
        end
    end

    assign rx_delta = m_rx_event_count - last_rx_reg;

    // A stalled result holds its word.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_status)
            && $stable(m_data_valid) && $stable(m_rx_event_count)
            && $stable(m_tx_event_count) && $stable(m_tx_irq_enable))
        else $error("result word changed while stalled");

    // No new word is taken over a result that is still waiting.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted over a stalled result");

    // Every accepted word yields a result in the next cycle.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");

    // Successive results advance the receive count by at most one.
    a_rx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && have_last_reg |-> (rx_delta == '0) || (rx_delta == COUNT_W'(1)))
        else $error("receive event count jumped");

endmodule

bind uart_dual_ring_queue udrq_checker u_udrq_checker (.*);
